>>> hdl/smm_pkg.sv
// Package for the min/max stack: operation and status codes, the stored entry
// type and the sizing defaults. No dependencies.
package smm_pkg;

   localparam int DATA_W        = 32;
   localparam int DEFAULT_DEPTH = 128;
   localparam int OPCODE_W      = 2;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 8;

   // Operation codes; the unused code behaves as a query.
   localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

   localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;

   // One stack slot: the value and the running extremes at or below it.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] min_value;
      logic signed [DATA_W-1:0] max_value;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{value: MOST_NEG, min_value: MOST_NEG,
                                         max_value: MOST_NEG};

endpackage

>>> hdl/smm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module smm_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/stack_with_min_max_unit.sv
// Top level of the min/max stack: control sequencer, count register and
// result registers. Depends on smm_pkg and smm_ram.
//
// Usage:
// A command transfer happens at a rising clock edge where start is high and
// busy is low; req_opcode selects push, pop or query and req_push_value
// carries the value for a push. Every command produces exactly one result,
// presented on the rsp_ ports for a single cycle while rsp_valid is high:
// a status (ok, overflow on a refused push, underflow on a refused pop), the
// entry count, and the top, minimum and maximum after the command. An empty
// stack reports the most negative value for all three.
// Each entry lives in one synchronous RAM next to the running minimum and
// maximum of everything at or below it, so one RAM read gives all three.
// A command proceeds as follows: in the accept cycle the RAM address of the
// relevant slot is issued, in the following cycle the RAM data is used, a
// push writes its new slot, and the result registers load. rsp_valid rises
// in the cycle after that. busy stays high while a command executes, so a
// new command cannot be transferred until the previous one has completed
// its RAM read and write-back.
// Reset empties the stack immediately; the RAM contents need no clearing
// because slot data at or above the count is never used. The receiver
// cannot stall: a result is lost if it is not taken in its one valid cycle.
module stack_with_min_max_unit #(
   parameter int DEPTH = smm_pkg::DEFAULT_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [smm_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic signed [smm_pkg::DATA_W-1:0]      req_push_value,
   output logic                                   rsp_valid,
   output logic [smm_pkg::STATUS_W-1:0]           rsp_status,
   output logic [smm_pkg::COUNT_OUT_W-1:0]        rsp_entry_count,
   output logic signed [smm_pkg::DATA_W-1:0]      rsp_top_value,
   output logic signed [smm_pkg::DATA_W-1:0]      rsp_min_value,
   output logic signed [smm_pkg::DATA_W-1:0]      rsp_max_value
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = $bits(smm_pkg::entry_type);

   // Sequencer states: waiting for a command, or using the RAM read data.
   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [smm_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic signed [smm_pkg::DATA_W-1:0] value_ff, value_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [smm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;
   smm_pkg::entry_type rsp_entry_ff, rsp_entry_in;

   logic accept;
   logic [CW-1:0] rd_index;
   logic wr_en;
   smm_pkg::entry_type wr_entry;
   smm_pkg::entry_type rd_entry;
   logic [EW-1:0] rd_bits;

   assign busy   = (state_ff == S_EXEC);
   assign accept = start && !busy;

   // A pop exposes the slot below the top; push and query look at the top.
   // With an empty stack the index wraps, and the data read is ignored.
   assign rd_index = (req_opcode == smm_pkg::OP_POP) ? count_ff - CW'(2)
                                                     : count_ff - CW'(1);

   smm_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (rd_index[AW-1:0]),
      .rd_data (rd_bits)
   );

   assign rd_entry = smm_pkg::entry_type'(rd_bits);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_entry_in  = rsp_entry_ff;
      wr_en         = 1'b0;

      // The new slot for a push: its own value, and the extremes merged with
      // the slot below unless this is the first entry.
      wr_entry.value = value_ff;
      if (count_ff == '0) begin
         wr_entry.min_value = value_ff;
         wr_entry.max_value = value_ff;
      end else begin
         wr_entry.min_value = (value_ff < rd_entry.min_value) ? value_ff
                                                              : rd_entry.min_value;
         wr_entry.max_value = (rd_entry.max_value < value_ff) ? value_ff
                                                              : rd_entry.max_value;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
               op_in    = req_opcode;
               value_in = req_push_value;
            end
         end
         S_EXEC: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = smm_pkg::STAT_OK;
            rsp_count_in  = count_ff;
            rsp_entry_in  = (count_ff == '0) ? smm_pkg::EMPTY_ENTRY : rd_entry;
            case (op_ff)
               smm_pkg::OP_PUSH: begin
                  if (count_ff == CW'(DEPTH)) begin
                     // Full: nothing changes, the current top is reported.
                     rsp_status_in = smm_pkg::STAT_OVERFLOW;
                  end else begin
                     wr_en        = 1'b1;
                     count_in     = count_ff + CW'(1);
                     rsp_count_in = count_ff + CW'(1);
                     rsp_entry_in = wr_entry;
                  end
               end
               smm_pkg::OP_POP: begin
                  if (count_ff == '0) begin
                     rsp_status_in = smm_pkg::STAT_UNDERFLOW;
                  end else begin
                     count_in     = count_ff - CW'(1);
                     rsp_count_in = count_ff - CW'(1);
                     // Popping the last entry leaves the stack empty.
                     rsp_entry_in = (count_ff == CW'(1)) ? smm_pkg::EMPTY_ENTRY
                                                         : rd_entry;
                  end
               end
               default: begin
                  // Query and the unused code leave the stack as it is.
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = smm_pkg::COUNT_OUT_W'(rsp_count_ff);
   assign rsp_top_value   = rsp_entry_ff.value;
   assign rsp_min_value   = rsp_entry_ff.min_value;
   assign rsp_max_value   = rsp_entry_ff.max_value;

endmodule

>>> test/tb_stack_with_min_max_unit.sv
// Self-checking testbench for stack_with_min_max_unit: random and directed push, pop and query
// commands, each checked against an in-bench prediction of the min/max stack.
// Depends on smm_pkg and the RTL of stack_with_min_max_unit.
`timescale 1ns / 1ps

module tb_stack_with_min_max_unit;

   localparam int DEPTH = smm_pkg::DEFAULT_DEPTH;

   // The package names three opcodes. The fourth code is unused and must behave as a query.
   localparam logic [smm_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;

   // One result of the block, or one prediction of it.
   typedef struct {
      logic [smm_pkg::STATUS_W-1:0]    status;
      logic [smm_pkg::COUNT_OUT_W-1:0] entry_count;
      logic signed [smm_pkg::DATA_W-1:0] top_value;
      logic signed [smm_pkg::DATA_W-1:0] min_value;
      logic signed [smm_pkg::DATA_W-1:0] max_value;
   } stack_result_type;

   // The scoreboard keeps its own copy of the stack. It predicts one result for every command
   // transfer. Results are checked in order against the oldest prediction still waiting.
   class minmax_scoreboard;
      logic signed [smm_pkg::DATA_W-1:0] value_mem [DEPTH];
      logic signed [smm_pkg::DATA_W-1:0] low_mem [DEPTH];
      logic signed [smm_pkg::DATA_W-1:0] high_mem [DEPTH];
      int depth_now;
      stack_result_type pending_results[$];
      int error_count, commands, pushes, pops, queries, spare_ops;
      int overflows, underflows, deepest, results_seen;

      function new();
         depth_now = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t ns: %s", $time, msg);
         error_count++;
      endtask

      // Apply one accepted command to the stack copy, and queue the result that it must produce.
      function void note_command(logic [smm_pkg::OPCODE_W-1:0] op,
                                 logic signed [smm_pkg::DATA_W-1:0] val);
         stack_result_type r;
         logic signed [smm_pkg::DATA_W-1:0] lo, hi;
         r.status = smm_pkg::STAT_OK;
         commands++;
         case (op)
            smm_pkg::OP_PUSH: begin
               pushes++;
               if (depth_now >= DEPTH) begin
                  r.status = smm_pkg::STAT_OVERFLOW;
                  overflows++;
               end else begin
                  lo = val;
                  hi = val;
                  if (depth_now > 0) begin
                     if (low_mem[depth_now-1] < val) lo = low_mem[depth_now-1];
                     if (high_mem[depth_now-1] > val) hi = high_mem[depth_now-1];
                  end
                  value_mem[depth_now] = val;
                  low_mem[depth_now] = lo;
                  high_mem[depth_now] = hi;
                  depth_now++;
                  if (depth_now > deepest) deepest = depth_now;
               end
            end
            smm_pkg::OP_POP: begin
               pops++;
               if (depth_now == 0) begin
                  r.status = smm_pkg::STAT_UNDERFLOW;
                  underflows++;
               end else begin
                  depth_now--;
               end
            end
            default: begin
               queries++;
               if (op == OP_SPARE) spare_ops++;
            end
         endcase
         r.entry_count = smm_pkg::COUNT_OUT_W'(depth_now);
         if (depth_now == 0) begin
            r.top_value = smm_pkg::MOST_NEG;
            r.min_value = smm_pkg::MOST_NEG;
            r.max_value = smm_pkg::MOST_NEG;
         end else begin
            r.top_value = value_mem[depth_now-1];
            r.min_value = low_mem[depth_now-1];
            r.max_value = high_mem[depth_now-1];
         end
         pending_results.push_back(r);
      endfunction

      // Compare one observed result, field by field, with the oldest prediction.
      task check_result(stack_result_type got);
         stack_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            report($sformatf("result with no command outstanding (status %0d count %0d)",
                             got.status, got.entry_count));
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, predicted %0d", got.status, want.status));
         if (got.entry_count !== want.entry_count)
            report($sformatf("entry count %0d, predicted %0d",
                             got.entry_count, want.entry_count));
         if (got.top_value !== want.top_value)
            report($sformatf("top %0d, predicted %0d", got.top_value, want.top_value));
         if (got.min_value !== want.min_value)
            report($sformatf("minimum %0d, predicted %0d", got.min_value, want.min_value));
         if (got.max_value !== want.max_value)
            report($sformatf("maximum %0d, predicted %0d", got.max_value, want.max_value));
      endtask
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [smm_pkg::OPCODE_W-1:0] req_opcode;
   logic signed [smm_pkg::DATA_W-1:0] req_push_value;
   logic rsp_valid;
   logic [smm_pkg::STATUS_W-1:0] rsp_status;
   logic [smm_pkg::COUNT_OUT_W-1:0] rsp_entry_count;
   logic signed [smm_pkg::DATA_W-1:0] rsp_top_value;
   logic signed [smm_pkg::DATA_W-1:0] rsp_min_value;
   logic signed [smm_pkg::DATA_W-1:0] rsp_max_value;

   minmax_scoreboard model;
   logic signed [smm_pkg::DATA_W-1:0] last_value;
   bit quiet_burst;

   stack_with_min_max_unit #(.DEPTH(DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_top_value  (rsp_top_value),
      .rsp_min_value  (rsp_min_value),
      .rsp_max_value  (rsp_max_value)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs or stops giving results. The slowest correct run is
   // every command waiting out the longest gap, which takes about half a millisecond.
   initial begin
      #5_000_000;
      $display("stack_with_min_max_unit regression: fail");
      $finish;
   end

   // The receiver cannot stall. Every cycle with rsp_valid high is a result, and it is checked
   // at the rising edge that closes that cycle. Results during reset are ignored.
   always @(posedge clock) begin
      stack_result_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.status = rsp_status;
         got.entry_count = rsp_entry_count;
         got.top_value = rsp_top_value;
         got.min_value = rsp_min_value;
         got.max_value = rsp_max_value;
         model.check_result(got);
      end
   end

   // An idle gap before a command. Most gaps are short and a few are long. A burst marked
   // quiet has no gaps at all, so that back-to-back commands are also covered.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet_burst || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Push values mix full-range noise and small values that give many ties. They also include
   // the signed extremes and repeats of the last value pushed.
   function automatic logic signed [smm_pkg::DATA_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return $urandom;
      if (roll < 70) return $signed($urandom_range(0, 20)) - 10;
      if (roll < 85) begin
         case ($urandom_range(0, 4))
            0: return smm_pkg::MOST_NEG;
            1: return smm_pkg::MOST_NEG + 1;
            2: return 32'sh7fff_ffff;
            3: return -1;
            default: return 0;
         endcase
      end
      return last_value;
   endfunction

   // One command transfer. Inputs change only at the falling edge. The command is taken at
   // the first rising edge where busy is low. When there is no gap, start stays high from the
   // previous command, and only the payload changes.
   task automatic issue_command(input logic [smm_pkg::OPCODE_W-1:0] op,
                                input logic signed [smm_pkg::DATA_W-1:0] val,
                                input int unsigned gap);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_push_value <= val;
      do @(posedge clock); while (busy !== 1'b0);
      model.note_command(op, val);
      if (op == smm_pkg::OP_PUSH) last_value = val;
   endtask

   initial begin
      int unsigned issued, burst_len, roll, mode;
      logic [smm_pkg::OPCODE_W-1:0] op;

      model = new();
      last_value = 0;
      quiet_burst = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = smm_pkg::OP_QUERY;
      req_push_value = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. It covers queries and refused pops on the empty stack, and the spare
      // opcode. The signed extremes and a duplicate are pushed, then popped one by one, so that
      // every older minimum and maximum comes back. Pop and query carry random values, which
      // the block must ignore.
      issue_command(smm_pkg::OP_QUERY, $urandom, 0);
      issue_command(smm_pkg::OP_POP, $urandom, 0);
      issue_command(OP_SPARE, $urandom, 1);
      issue_command(smm_pkg::OP_PUSH, 5, 0);
      issue_command(smm_pkg::OP_PUSH, smm_pkg::MOST_NEG, 0);
      issue_command(smm_pkg::OP_PUSH, 32'sh7fff_ffff, 2);
      issue_command(smm_pkg::OP_PUSH, 0, 0);
      issue_command(smm_pkg::OP_PUSH, -1, 0);
      issue_command(smm_pkg::OP_PUSH, 5, 0);
      issue_command(smm_pkg::OP_QUERY, $urandom, 0);
      issue_command(OP_SPARE, $urandom, 0);
      repeat (6) issue_command(smm_pkg::OP_POP, $urandom, 0);
      issue_command(smm_pkg::OP_POP, $urandom, 3);
      issue_command(smm_pkg::OP_PUSH, 32'sh7fff_ffff, 0);
      issue_command(smm_pkg::OP_PUSH, smm_pkg::MOST_NEG, 0);
      issue_command(smm_pkg::OP_POP, $urandom, 0);
      issue_command(smm_pkg::OP_POP, $urandom, 0);

      // Random part, in bursts. Fill bursts are mostly pushes and run the stack into overflow.
      // Drain bursts are mostly pops and run it into underflow. Mixed bursts wander in between.
      issued = 0;
      while (issued < 1300) begin
         mode = $urandom_range(0, 9);
         quiet_burst = ($urandom_range(0, 3) == 0);
         if (mode < 5) burst_len = $urandom_range(100, 180);
         else burst_len = $urandom_range(10, 60);
         repeat (burst_len) begin
            roll = $urandom_range(0, 99);
            if (mode < 3)
               op = (roll < 90) ? smm_pkg::OP_PUSH :
                    (roll < 95) ? smm_pkg::OP_POP : smm_pkg::OP_QUERY;
            else if (mode < 5)
               op = (roll < 90) ? smm_pkg::OP_POP :
                    (roll < 95) ? smm_pkg::OP_PUSH : OP_SPARE;
            else
               op = (roll < 45) ? smm_pkg::OP_PUSH : (roll < 80) ? smm_pkg::OP_POP :
                    (roll < 90) ? smm_pkg::OP_QUERY : OP_SPARE;
            issue_command(op, (op == smm_pkg::OP_PUSH) ? pick_value() : $urandom, pick_gap());
            issued++;
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // Wait for every outstanding result. Then wait a few cycles more, so that a stray extra
      // result would still be caught. The timeout above bounds this wait.
      while (model.pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Covered %0d commands: %0d pushes, %0d pops, %0d queries (%0d spare opcode).",
               model.commands, model.pushes, model.pops, model.queries, model.spare_ops);
      $display("Refused pushes on full stack: %0d, refused pops on empty stack: %0d, %0s%0d.",
               model.overflows, model.underflows, "deepest fill: ", model.deepest);
      if (model.error_count == 0 && model.pending_results.size() == 0) begin
         $display("stack_with_min_max_unit regression: pass");
      end else begin
         $display("stack_with_min_max_unit regression: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/smm_pkg.sv
hdl/smm_ram.sv
hdl/stack_with_min_max_unit.sv
test/tb_stack_with_min_max_unit.sv
